### design/binary_trie_longest_prefix_match_assert.svh
// assertion macros for the binary trie route table checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define BINARY_TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// same-cycle implication
`define BTLPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("btlpm assertion failed");

// next-cycle implication
`define BTLPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("btlpm assertion failed");

`endif

### design/btlpm_pkg.sv
// shared types and constants for the binary trie route table
// no dependencies
package btlpm_pkg;

  localparam int NODE_COUNT = 1024;
  localparam int ADDR_BITS  = 32;

  localparam int IDX_W    = $clog2(NODE_COUNT);
  localparam int FREE_W   = $clog2(NODE_COUNT + 1);
  localparam int LVL_W    = $clog2(ADDR_BITS + 1);
  localparam int LEN_W    = 6;
  localparam int PORT_W   = 11;
  localparam int STATUS_W = 2;

  localparam logic [PORT_W-1:0] NO_PORT = '1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERT_DONE = 2'd0,
    STATUS_LOOKUP_DONE = 2'd1,
    STATUS_POOL_FULL   = 2'd2
  } status_e;

  // one trie node: child links (0 = none) and port
  typedef struct packed {
    idx_t              left;
    idx_t              right;
    logic [PORT_W-1:0] port;
  } node_t;

  // node memory access from the walker
  typedef struct packed {
    logic  rd_en;
    idx_t  rd_addr;
    logic  wr_en;
    idx_t  wr_addr;
    node_t wr_word;
  } mem_req_t;

  typedef struct packed {
    logic [PORT_W-1:0] found_port;
    status_e           status;
  } result_t;

endpackage

### design/btlpm_req_if.sv
// request and response channel interfaces of the trie route table
// depends on btlpm_pkg
interface btlpm_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  kind;
  logic [btlpm_pkg::ADDR_BITS-1:0]       address;
  logic [btlpm_pkg::LEN_W-1:0]           prefix_len;
  logic signed [btlpm_pkg::PORT_W-1:0]   port;

  modport source (output valid, kind, address, prefix_len, port, input ready);
  modport sink (input valid, kind, address, prefix_len, port, output ready);
endinterface

interface btlpm_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [btlpm_pkg::PORT_W-1:0]   found_port;
  logic [btlpm_pkg::STATUS_W-1:0]        status;

  modport source (output valid, found_port, status, input ready);
  modport sink (input valid, found_port, status, output ready);
endinterface

### design/btlpm_node_mem.sv
// trie node store: node memory for allocated nodes, root node in flops
// depends on btlpm_pkg
module btlpm_node_mem (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  btlpm_pkg::mem_req_t mem_req_i,
  output btlpm_pkg::node_t    rd_word_o,
  output btlpm_pkg::node_t    root_word_o
);

  btlpm_pkg::node_t mem [btlpm_pkg::NODE_COUNT];
  btlpm_pkg::node_t rd_q;
  btlpm_pkg::node_t root_q;

  // node memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en && (mem_req_i.wr_addr != '0)) begin
      mem[mem_req_i.wr_addr] <= mem_req_i.wr_word;
    end
    if (mem_req_i.rd_en) begin
      rd_q <= mem[mem_req_i.rd_addr];
    end
  end

  // root node: no children and no port after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '{left: '0, right: '0, port: btlpm_pkg::NO_PORT};
    end else if (mem_req_i.wr_en && (mem_req_i.wr_addr == '0)) begin
      root_q <= mem_req_i.wr_word;
    end
  end

  assign rd_word_o   = rd_q;
  assign root_word_o = root_q;

endmodule

### design/btlpm_walk.sv
// trie walker: address shift register, level counter and node allocator
// depends on btlpm_pkg, btlpm_req_if
module btlpm_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  btlpm_req_if.sink            req_i,
  output btlpm_pkg::mem_req_t  mem_req_o,
  input  btlpm_pkg::node_t     rd_word_i,
  input  btlpm_pkg::node_t     root_word_i,
  output logic                 res_valid_o,
  output btlpm_pkg::result_t   res_o,
  input  logic                 res_ready_i
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_WALK   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  // where the current node's word comes from
  typedef enum logic [2:0] {
    SRC_ROOT  = 3'b001,
    SRC_MEM   = 3'b010,
    SRC_FRESH = 3'b100
  } src_e;

  state_e state_q, state_d;
  src_e   src_q, src_d;
  logic [btlpm_pkg::FREE_W-1:0]    next_free_q, next_free_d;
  logic [btlpm_pkg::ADDR_BITS-1:0] addr_sr_q, addr_sr_d;
  logic [btlpm_pkg::LVL_W-1:0]     remain_q, remain_d;
  logic [btlpm_pkg::PORT_W-1:0]    port_q, port_d;
  logic [btlpm_pkg::PORT_W-1:0]    best_q, best_d;
  btlpm_pkg::kind_e                kind_q, kind_d;
  btlpm_pkg::idx_t                 cur_q, cur_d;
  btlpm_pkg::result_t              res_q, res_d;

  btlpm_pkg::node_t  word;
  btlpm_pkg::node_t  linked;
  btlpm_pkg::idx_t   nxt;
  btlpm_pkg::idx_t   new_idx;
  logic              dir;
  logic              pool_full;
  logic [btlpm_pkg::PORT_W-1:0] best_upd;

  // current node word
  always_comb begin
    case (src_q)
      SRC_ROOT:  word = root_word_i;
      SRC_MEM:   word = rd_word_i;
      SRC_FRESH: word = '{left: '0, right: '0, port: btlpm_pkg::NO_PORT};
      default:   word = root_word_i;
    endcase
  end

  assign dir       = addr_sr_q[btlpm_pkg::ADDR_BITS-1];
  assign nxt       = dir ? word.right : word.left;
  assign new_idx   = next_free_q[btlpm_pkg::IDX_W-1:0];
  assign pool_full = (next_free_q == btlpm_pkg::FREE_W'(btlpm_pkg::NODE_COUNT));
  assign best_upd  = (word.port != btlpm_pkg::NO_PORT) ? word.port : best_q;

  // current word with the walk-direction link pointed at a new node
  always_comb begin
    linked = word;
    if (dir) begin
      linked.right = new_idx;
    end else begin
      linked.left = new_idx;
    end
  end

  // walk sequencer, one trie level per cycle
  always_comb begin
    state_d     = state_q;
    src_d       = src_q;
    next_free_d = next_free_q;
    addr_sr_d   = addr_sr_q;
    remain_d    = remain_q;
    port_d      = port_q;
    best_d      = best_q;
    kind_d      = kind_q;
    cur_d       = cur_q;
    res_d       = res_q;
    mem_req_o   = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d    = btlpm_pkg::kind_e'(req_i.kind);
          addr_sr_d = req_i.address;
          port_d    = req_i.port[btlpm_pkg::PORT_W-1] ? btlpm_pkg::NO_PORT : req_i.port;
          best_d    = btlpm_pkg::NO_PORT;
          cur_d     = '0;
          src_d     = SRC_ROOT;
          state_d   = ST_WALK;
          if (req_i.kind == btlpm_pkg::KIND_LOOKUP) begin
            remain_d = btlpm_pkg::LVL_W'(btlpm_pkg::ADDR_BITS);
          end else if (int'(req_i.prefix_len) > btlpm_pkg::ADDR_BITS) begin
            remain_d = btlpm_pkg::LVL_W'(btlpm_pkg::ADDR_BITS);
          end else begin
            remain_d = btlpm_pkg::LVL_W'(req_i.prefix_len);
          end
        end
      end

      ST_WALK: begin
        if (kind_q == btlpm_pkg::KIND_LOOKUP) begin
          best_d = best_upd;
          if ((remain_q == '0) || (nxt == '0)) begin
            res_d   = '{found_port: best_upd, status: btlpm_pkg::STATUS_LOOKUP_DONE};
            state_d = ST_FINISH;
          end else begin
            mem_req_o.rd_en   = 1'b1;
            mem_req_o.rd_addr = nxt;
            cur_d     = nxt;
            src_d     = SRC_MEM;
            remain_d  = remain_q - btlpm_pkg::LVL_W'(1);
            addr_sr_d = {addr_sr_q[btlpm_pkg::ADDR_BITS-2:0], 1'b0};
          end
        end else if (remain_q == '0) begin
          // last node of the route takes the port
          mem_req_o.wr_en        = 1'b1;
          mem_req_o.wr_addr      = cur_q;
          mem_req_o.wr_word      = word;
          mem_req_o.wr_word.port = port_q;
          res_d   = '{found_port: btlpm_pkg::NO_PORT, status: btlpm_pkg::STATUS_INSERT_DONE};
          state_d = ST_FINISH;
        end else if (nxt != '0) begin
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = nxt;
          cur_d     = nxt;
          src_d     = SRC_MEM;
          remain_d  = remain_q - btlpm_pkg::LVL_W'(1);
          addr_sr_d = {addr_sr_q[btlpm_pkg::ADDR_BITS-2:0], 1'b0};
        end else if (pool_full) begin
          // pool exhausted: store the current node as it stands and stop
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = cur_q;
          mem_req_o.wr_word = word;
          res_d   = '{found_port: btlpm_pkg::NO_PORT, status: btlpm_pkg::STATUS_POOL_FULL};
          state_d = ST_FINISH;
        end else begin
          // allocate a child, write back the parent, keep the new node in flight
          mem_req_o.wr_en   = 1'b1;
          mem_req_o.wr_addr = cur_q;
          mem_req_o.wr_word = linked;
          cur_d       = new_idx;
          src_d       = SRC_FRESH;
          next_free_d = next_free_q + btlpm_pkg::FREE_W'(1);
          remain_d    = remain_q - btlpm_pkg::LVL_W'(1);
          addr_sr_d   = {addr_sr_q[btlpm_pkg::ADDR_BITS-2:0], 1'b0};
        end
      end

      ST_FINISH: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      src_q       <= SRC_ROOT;
      next_free_q <= btlpm_pkg::FREE_W'(1);
    end else begin
      state_q     <= state_d;
      src_q       <= src_d;
      next_free_q <= next_free_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    addr_sr_q <= addr_sr_d;
    remain_q  <= remain_d;
    port_q    <= port_d;
    best_q    <= best_d;
    kind_q    <= kind_d;
    cur_q     <= cur_d;
    res_q     <= res_d;
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FINISH);
  assign res_o       = res_q;

endmodule

### design/binary_trie_longest_prefix_match.sv
// IPv4 longest-prefix-match route table, top level with output register
// depends on btlpm_pkg, btlpm_req_if, btlpm_rsp_if, btlpm_walk, btlpm_node_mem
//
// Routes live in a unibit binary trie of 1024 nodes; node 0 is the root and the
// rest are handed out in order and never freed. One item is worked on at a time.
// The walker visits one trie level per clock through the single read port of the
// node memory, shifting the address out msb first. It walks at most 32 levels
// (a lookup stops early at a missing child, an insert walks min(prefix_len, 32)
// levels). A new item is taken once the walker is idle; a result waiting in the
// output register does not hold it off. An insert that needs a node after the
// pool is used up returns status 2 and keeps the nodes it already made. Port -1
// (any negative port) clears a node's port; a lookup returns -1 when no node on
// the path has a port.
module binary_trie_longest_prefix_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  btlpm_req_if.sink   req_i,
  btlpm_rsp_if.source rsp_o
);

  btlpm_pkg::mem_req_t mem_req;
  btlpm_pkg::node_t    rd_word;
  btlpm_pkg::node_t    root_word;
  btlpm_pkg::result_t  res;
  logic                res_valid;
  logic                res_ready;

  logic                            out_valid_q;
  logic [btlpm_pkg::PORT_W-1:0]    out_port_q;
  logic [btlpm_pkg::STATUS_W-1:0]  out_status_q;

  btlpm_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .mem_req_o   (mem_req),
    .rd_word_i   (rd_word),
    .root_word_i (root_word),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  btlpm_node_mem u_node_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mem_req_i   (mem_req),
    .rd_word_o   (rd_word),
    .root_word_o (root_word)
  );

  // output register, refilled in the cycle it is taken
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_port_q   <= res.found_port;
      out_status_q <= res.status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found_port = out_port_q;
  assign rsp_o.status     = out_status_q;

endmodule

### design/btlpm_checker.sv
// port-level checks for the trie route table, bound to the top level
// depends on btlpm_pkg and binary_trie_longest_prefix_match_assert.svh
`include "binary_trie_longest_prefix_match_assert.svh"

module btlpm_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [btlpm_pkg::PORT_W-1:0]    rsp_found_port_i,
  input logic [btlpm_pkg::STATUS_W-1:0]  rsp_status_i
);

  // only the three defined status codes leave the block
  `BTLPM_ASSERT_IMP(a_status_code, rsp_valid_i, (rsp_status_i == btlpm_pkg::STATUS_INSERT_DONE) || (rsp_status_i == btlpm_pkg::STATUS_LOOKUP_DONE) || (rsp_status_i == btlpm_pkg::STATUS_POOL_FULL))

  // insert results never carry a port
  `BTLPM_ASSERT_IMP(a_insert_no_port, rsp_valid_i && (rsp_status_i != btlpm_pkg::STATUS_LOOKUP_DONE), rsp_found_port_i == btlpm_pkg::NO_PORT)

  // the walker is busy right after it takes an item
  `BTLPM_ASSERT_NXT(a_busy_after_accept, req_valid_i && req_ready_i, !req_ready_i)

  // a stalled result holds
  `BTLPM_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_found_port_i) && $stable(rsp_status_i))

endmodule

bind binary_trie_longest_prefix_match btlpm_checker u_btlpm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_found_port_i (rsp_o.found_port),
  .rsp_status_i     (rsp_o.status)
);
